[hw/rtl/tccs_pkg.sv]
package tccs_pkg;

   // Request kinds
   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Port field widths
   localparam int CODE_W  = 8;
   localparam int COLOR_W = 8;
   localparam int CELL_W  = 16;
   localparam int PROW_W  = 5;
   localparam int PCOL_W  = 7;

   // Control codes
   localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
   localparam logic [CODE_W-1:0] CODE_RETURN    = 8'd13;
   localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
   localparam logic [CODE_W-1:0] CODE_SPACE     = 8'd32;

   // Cell seen after reset: space, light green on black
   localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h0A;
   localparam logic [CELL_W-1:0]  RESET_CELL  = {RESET_COLOR, CODE_SPACE};

   typedef logic [CELL_W-1:0] cell_type;

endpackage

[hw/rtl/tccs_screen_ram.sv]
module tccs_screen_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     addr,
   input  tccs_pkg::cell_type wr_data,
   output tccs_pkg::cell_type rd_data
);
   import tccs_pkg::*;

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   // Write at the address, read it back registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/tccs_addr_map.sv]
module tccs_addr_map #(
   parameter int ROWS    = 25,
   parameter int COLUMNS = 80,
   parameter int RW      = 5,
   parameter int CW      = 7,
   parameter int AW      = 11
) (
   input  logic [RW-1:0] top_row,
   input  logic [RW-1:0] row,
   input  logic [CW-1:0] col,
   output logic [AW-1:0] addr
);
   import tccs_pkg::*;

   localparam logic [RW:0]   ROWS_X = (RW+1)'(ROWS);
   localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

   logic [RW:0]   row_sum;
   logic [RW-1:0] phys_row;

   // Rotate the logical row by the top-of-screen pointer
   always_comb begin
      row_sum = {1'b0, top_row} + {1'b0, row};
      if (row_sum >= ROWS_X) begin
         row_sum = row_sum - ROWS_X;
      end
      phys_row = row_sum[RW-1:0];
   end

   // Row-major cell address
   assign addr = AW'(phys_row) * COLS_A + AW'(col);

endmodule

[hw/rtl/text_console_cursor_scroll.sv]
// Text console engine: a ROWS x COLUMNS screen of 16-bit cells and a cursor.
// Requests come in on req_* (valid/ready); one response per request leaves on
// rsp_* (valid/ready). A put (req_type 0) interprets char_code at the cursor:
// newline, carriage return and backspace move the cursor, any other byte is
// written in text_color and the cursor advances. A read (req_type 1) returns
// the cell at read_row/read_col, zero when out of range.
// A put without scroll and an out-of-range read pass through a pending-result
// register into the output register; an in-range read first waits in a
// read-wait state for the registered screen RAM data. A scroll advances a
// rotating top-row pointer and blanks the new bottom row one cell per cycle
// through the single RAM port. Requests are handled one at a time: the next
// is accepted once the previous one is finished and its result has left the
// pending register. After reset the block clears the screen RAM to space on
// 0x0A, one cell a cycle, with req_ready low; the cursor resets to 0,0.
// The response sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, at most one more finished response is
// held internally and req_ready drops until the output register frees.
module text_console_cursor_scroll #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   input  logic [tccs_pkg::CODE_W-1:0]  req_char_code,
   input  logic [tccs_pkg::COLOR_W-1:0] req_text_color,
   input  logic [tccs_pkg::PROW_W-1:0]  req_read_row,
   input  logic [tccs_pkg::PCOL_W-1:0]  req_read_col,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tccs_pkg::CELL_W-1:0]  rsp_cell_value,
   output logic [tccs_pkg::PROW_W-1:0]  rsp_cursor_row,
   output logic [tccs_pkg::PCOL_W-1:0]  rsp_cursor_col,
   output logic                         rsp_did_scroll
);
   import tccs_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int AW    = $clog2(CELLS);

   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
   localparam logic [AW-1:0] LAST_ADR = AW'(CELLS - 1);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_RDWAIT = 2'd2;
   localparam logic [1:0] ST_BLANK  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0]      fill_col_ff, fill_col_in;
   logic [COLOR_W-1:0] fill_color_ff, fill_color_in;
   logic [RW-1:0]      top_ff, top_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic               res_pend_ff, res_pend_in;
   cell_type           res_value_ff, res_value_in;
   logic               res_scroll_ff, res_scroll_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cell_type           rsp_value_ff, rsp_value_in;
   logic [PROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [PCOL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic               rsp_scroll_ff, rsp_scroll_in;

   logic               accept;
   logic               use_clr;
   logic               in_range;
   logic [RW-1:0]      map_row;
   logic [CW-1:0]      map_col;
   logic [AW-1:0]      map_addr;
   logic               mem_we;
   logic [AW-1:0]      mem_addr;
   cell_type           mem_wdata;
   cell_type           mem_rdata;

   tccs_addr_map #(
      .ROWS(ROWS), .COLUMNS(COLUMNS), .RW(RW), .CW(CW), .AW(AW)
   ) u_addr_map (
      .top_row(top_ff),
      .row    (map_row),
      .col    (map_col),
      .addr   (map_addr)
   );

   tccs_screen_ram #(
      .DEPTH(CELLS), .AW(AW)
   ) u_screen_ram (
      .clock  (clock),
      .we     (mem_we),
      .addr   (mem_addr),
      .wr_data(mem_wdata),
      .rd_data(mem_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE) && !res_pend_ff;
   assign accept    = req_valid && req_ready;
   assign in_range  = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLUMNS);
   assign mem_addr  = use_clr ? clr_cnt_ff : map_addr;

   // Sequence requests, screen clear and row blanking
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      fill_col_in   = fill_col_ff;
      fill_color_in = fill_color_ff;
      top_in        = top_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      res_pend_in   = res_pend_ff;
      res_value_in  = res_value_ff;
      res_scroll_in = res_scroll_ff;
      map_row       = row_ff;
      map_col       = col_ff;
      mem_we        = 1'b0;
      mem_wdata     = {fill_color_ff, CODE_SPACE};
      use_clr       = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            use_clr   = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = RESET_CELL;
            if (clr_cnt_ff == LAST_ADR) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               res_value_in  = '0;
               res_scroll_in = 1'b0;
               if (req_type == REQ_READ) begin
                  map_row = RW'(req_read_row);
                  map_col = CW'(req_read_col);
                  if (in_range) begin
                     state_in = ST_RDWAIT;
                  end else begin
                     res_pend_in = 1'b1;
                  end
               end else begin
                  unique case (req_char_code)
                     CODE_NEWLINE: begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           top_in        = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
                           fill_col_in   = '0;
                           fill_color_in = req_text_color;
                           state_in      = ST_BLANK;
                        end else begin
                           row_in      = row_ff + 1'b1;
                           res_pend_in = 1'b1;
                        end
                     end
                     CODE_RETURN: begin
                        col_in      = '0;
                        res_pend_in = 1'b1;
                     end
                     CODE_BACKSPACE: begin
                        if (col_ff != '0) begin
                           col_in    = col_ff - 1'b1;
                           map_col   = col_ff - 1'b1;
                           mem_we    = 1'b1;
                           mem_wdata = {req_text_color, CODE_SPACE};
                        end
                        res_pend_in = 1'b1;
                     end
                     default: begin
                        mem_we    = 1'b1;
                        mem_wdata = {req_text_color, req_char_code};
                        if (col_ff == LAST_COL) begin
                           col_in = '0;
                           if (row_ff == LAST_ROW) begin
                              top_in        = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
                              fill_col_in   = '0;
                              fill_color_in = req_text_color;
                              state_in      = ST_BLANK;
                           end else begin
                              row_in      = row_ff + 1'b1;
                              res_pend_in = 1'b1;
                           end
                        end else begin
                           col_in      = col_ff + 1'b1;
                           res_pend_in = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         ST_RDWAIT: begin
            res_value_in  = mem_rdata;
            res_scroll_in = 1'b0;
            res_pend_in   = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_BLANK: begin
            // Bottom row maps to the old top row after the pointer moved
            map_col = fill_col_ff;
            mem_we  = 1'b1;
            if (fill_col_ff == LAST_COL) begin
               res_value_in  = '0;
               res_scroll_in = 1'b1;
               res_pend_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               fill_col_in = fill_col_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Move a finished response into the output register when it frees
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_scroll_in = rsp_scroll_ff;
      if (res_pend_ff && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_row_in    = PROW_W'(row_ff);
         rsp_col_in    = PCOL_W'(col_ff);
         rsp_scroll_in = res_scroll_ff;
         res_pend_in   = 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         top_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         res_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         top_ff       <= top_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         res_pend_ff  <= res_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      fill_col_ff   <= fill_col_in;
      fill_color_ff <= fill_color_in;
      res_value_ff  <= res_value_in;
      res_scroll_ff <= res_scroll_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_scroll_ff <= rsp_scroll_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_did_scroll = rsp_scroll_ff;

   // A scroll always leaves the cursor at the start of the last row
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_did_scroll |->
         rsp_cursor_row == PROW_W'(ROWS - 1) && rsp_cursor_col == '0)
      else $error("scroll response with cursor off the last row start");

   // No write while a read is in flight
   a_rdwait_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RDWAIT |-> !mem_we)
      else $error("screen write during read wait");

   // A pending response moves out when the output register is empty
   a_pend_drains: assert property (@(posedge clock) disable iff (reset)
      res_pend_ff && !rsp_valid_ff |=> rsp_valid_ff && !res_pend_ff)
      else $error("pending response not moved to output");

   // The top-row pointer holds while the bottom row is blanked
   a_blank_top_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BLANK && $past(state_ff) == ST_BLANK |-> $stable(top_ff))
      else $error("top row pointer moved during row blank");

endmodule
